[hw/rtl/chs_pkg.sv]
// Package: shared types, constants and codes of the chained hash set unit.
package chs_pkg;

	localparam int unsigned BucketsDefault  = 16;
	localparam int unsigned PoolSizeDefault = 64;
	localparam int unsigned ActionWidth     = 2;
	localparam int unsigned KeyWidth        = 16;
	localparam int unsigned StatusWidth     = 3;
	localparam int unsigned BucketOutWidth  = 4;

	typedef enum logic [ActionWidth-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_SPARE  = 2'd3
	} action_t;

	typedef enum logic [StatusWidth-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_DELETED   = 3'd2,
		ST_ABSENT    = 3'd3,
		ST_PRESENT   = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_HEAD,
		S_READ,
		S_CHECK,
		S_TAKE,
		S_LINK,
		S_UNLINK,
		S_FREE,
		S_DONE,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture input transaction
		logic hash_step;   // one decimal digit of the digit sum
		logic mod_step;    // one reduction step of the bucket sum
		logic head_read;   // cur <= head[bucket], prev <= null
		logic node_read;   // read node memory at cur
		logic advance;     // prev <= cur, cur <= next, step count up
		logic take;        // allocate node into new_q
		logic link;        // write the new node, and the bucket head if it has no predecessor
		logic unlink;      // bypass cur at predecessor
		logic free_node;   // push cur onto the free list
		logic set_status;
		status_t status;
		logic out_valid_set;
	} chs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		action_t action;
		logic    hash_done;
		logic    mod_done;
		logic    cur_is_node;
		logic    val_lt;
		logic    val_eq;
		logic    steps_done;
		logic    pool_avail;
		logic    out_taken;
	} chs_stat_t;

endpackage

[hw/rtl/chs_stream_if.sv]
// Interface: a valid/ready channel with a generic payload.
interface chs_stream_if #(parameter int unsigned Width = 1);
	logic             valid;
	logic             ready;
	logic [Width-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/chs_ctrl.sv]
// Controller state machine of the chained hash set unit.
module chs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  chs_pkg::chs_stat_t  stat,
	output chs_pkg::chs_cmd_t   cmd
);

	chs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.status = chs_pkg::ST_ABSENT;
		in_ready = 1'b0;
		unique case (state_q)
			chs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = chs_pkg::S_HASH;
				end
			end
			chs_pkg::S_HASH: begin
				if (stat.hash_done) begin
					state_d = chs_pkg::S_MOD;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			chs_pkg::S_MOD: begin
				if (stat.mod_done) begin
					state_d = chs_pkg::S_HEAD;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			chs_pkg::S_HEAD: begin
				cmd.head_read = 1'b1;
				state_d = chs_pkg::S_READ;
			end
			chs_pkg::S_READ: begin
				cmd.node_read = 1'b1;
				state_d = chs_pkg::S_CHECK;
			end
			chs_pkg::S_CHECK: begin
				if (stat.action == chs_pkg::ACT_INSERT) begin
					if (stat.cur_is_node && stat.val_lt && !stat.steps_done) begin
						cmd.advance = 1'b1;
						state_d = chs_pkg::S_READ;
					end else if (stat.cur_is_node && stat.val_eq) begin
						cmd.set_status = 1'b1;
						cmd.status = chs_pkg::ST_DUPLICATE;
						state_d = chs_pkg::S_DONE;
					end else if (!stat.pool_avail) begin
						cmd.set_status = 1'b1;
						cmd.status = chs_pkg::ST_FULL;
						state_d = chs_pkg::S_DONE;
					end else begin
						cmd.take = 1'b1;
						state_d = chs_pkg::S_TAKE;
					end
				end else begin
					if (stat.cur_is_node && !stat.val_eq && !stat.steps_done) begin
						cmd.advance = 1'b1;
						state_d = chs_pkg::S_READ;
					end else if (stat.cur_is_node && stat.val_eq) begin
						cmd.set_status = 1'b1;
						if (stat.action == chs_pkg::ACT_DELETE) begin
							cmd.status = chs_pkg::ST_DELETED;
							state_d = chs_pkg::S_UNLINK;
						end else begin
							cmd.status = chs_pkg::ST_PRESENT;
							state_d = chs_pkg::S_DONE;
						end
					end else begin
						cmd.set_status = 1'b1;
						cmd.status = chs_pkg::ST_ABSENT;
						state_d = chs_pkg::S_DONE;
					end
				end
			end
			chs_pkg::S_TAKE: begin
				cmd.link = 1'b1;
				state_d = chs_pkg::S_LINK;
			end
			chs_pkg::S_LINK: begin
				cmd.set_status = 1'b1;
				cmd.status = chs_pkg::ST_INSERTED;
				state_d = chs_pkg::S_DONE;
			end
			chs_pkg::S_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d = chs_pkg::S_FREE;
			end
			chs_pkg::S_FREE: begin
				cmd.free_node = 1'b1;
				state_d = chs_pkg::S_DONE;
			end
			chs_pkg::S_DONE: begin
				cmd.out_valid_set = 1'b1;
				state_d = chs_pkg::S_OUT;
			end
			chs_pkg::S_OUT: begin
				// Hold the result until the receiver takes it.
				if (stat.out_taken) begin
					state_d = chs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = chs_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/chs_datapath.sv]
// Datapath of the chained hash set unit: digit sum, bucket heads, node pool.
module chs_datapath #(
	parameter int unsigned Buckets  = chs_pkg::BucketsDefault,
	parameter int unsigned PoolSize = chs_pkg::PoolSizeDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [chs_pkg::ActionWidth-1:0]      in_action,
	input  logic [chs_pkg::KeyWidth-1:0]         in_key,
	input  chs_pkg::chs_cmd_t                    cmd,
	output chs_pkg::chs_stat_t                   stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [chs_pkg::StatusWidth-1:0]      out_status,
	output logic [chs_pkg::BucketOutWidth-1:0]   out_bucket
);

	localparam int unsigned LinkW = $clog2(PoolSize + 1);
	localparam int unsigned IdxW  = (PoolSize > 1) ? $clog2(PoolSize) : 1;
	localparam int unsigned BW    = (Buckets > 1) ? $clog2(Buckets) : 1;
	localparam int unsigned SumW  = 6;   // five digits sum to at most 45
	localparam logic [LinkW-1:0] Nil = LinkW'(PoolSize);
	localparam logic [SumW-1:0]  BucketsC = SumW'(Buckets > 63 ? 63 : Buckets);
	localparam logic             BigBuckets = (Buckets > 45);

	logic [LinkW-1:0] head_q [Buckets];
	logic [chs_pkg::KeyWidth-1:0] node_value_mem [PoolSize];
	logic [LinkW-1:0]             node_next_mem  [PoolSize];

	chs_pkg::action_t action_q;
	logic [chs_pkg::KeyWidth-1:0] key_q, rem_q;
	logic [SumW-1:0] sum_q;
	logic [LinkW-1:0] cur_q, prev_q, free_q, fresh_q, new_q;
	logic [LinkW-1:0] steps_q;
	logic [chs_pkg::KeyWidth-1:0] rd_value_q;
	logic [LinkW-1:0] rd_next_q;
	logic [chs_pkg::StatusWidth-1:0] status_q;
	logic out_valid_q;
	logic [LinkW-1:0] free_next_raw, rd_next_free, new_q_d;
	logic link_pending;

	// Divide by ten through a reciprocal: q = (x * 52429) >> 19 is exact for 16 bits.
	logic [35:0] recip;
	logic [chs_pkg::KeyWidth-1:0] quot;
	logic [3:0] digit;
	assign recip = 36'(rem_q) * 36'd52429;
	assign quot  = recip[34:19];
	assign digit = 4'(rem_q - 16'(quot * 16'd10));

	logic [BW-1:0] bidx;
	assign bidx = BW'(sum_q);

	logic cur_node, free_node_ok, rd_next_ok;
	assign cur_node     = (cur_q < Nil);
	assign free_node_ok = (free_q < Nil);
	assign rd_next_ok   = (rd_next_q < Nil);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Buckets; i++) begin
				head_q[i] <= Nil;
			end
			free_q      <= Nil;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_valid_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.take) begin
				if (free_node_ok) begin
					free_q <= rd_next_free;
				end else begin
					fresh_q <= fresh_q + LinkW'(1);
				end
			end
			if (cmd.link && !(prev_q < Nil)) begin
				head_q[bidx] <= new_q_d;
			end
			if (cmd.unlink && !(prev_q < Nil)) begin
				head_q[bidx] <= rd_next_ok ? rd_next_q : Nil;
			end
			if (cmd.free_node) begin
				free_q <= cur_q;
			end
		end
	end

	// Free list pop: the next link of the free head is registered from the node
	// memory at one extra address on each node read; it is used only on take.
	always_ff @(posedge clk) begin
		if (cmd.node_read) begin
			free_next_raw <= node_next_mem[IdxW'(free_q)];
		end
	end
	assign rd_next_free = (free_next_raw < Nil) ? free_next_raw : Nil;
	assign new_q_d = new_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= chs_pkg::action_t'(in_action);
			key_q    <= in_key;
			rem_q    <= in_key;
			sum_q    <= '0;
		end
		if (cmd.hash_step) begin
			rem_q <= quot;
			sum_q <= sum_q + SumW'(digit);
		end
		if (cmd.mod_step) begin
			sum_q <= sum_q - BucketsC;
		end
		if (cmd.head_read) begin
			cur_q   <= head_q[bidx];
			prev_q  <= Nil;
			steps_q <= '0;
		end
		if (cmd.node_read) begin
			rd_value_q <= node_value_mem[IdxW'(cur_q)];
			rd_next_q  <= node_next_mem[IdxW'(cur_q)];
		end
		if (cmd.advance) begin
			prev_q  <= cur_q;
			cur_q   <= rd_next_q;
			steps_q <= steps_q + LinkW'(1);
		end
		if (cmd.take) begin
			new_q <= free_node_ok ? free_q : fresh_q;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
	end

	// The predecessor link of an insert is written in the cycle after the node.
	assign link_pending = (cmd.status == chs_pkg::ST_INSERTED);

	// Node memory: one write port, shared by link, unlink, free and the predecessor link of an insert.
	always_ff @(posedge clk) begin
		if (cmd.link) begin
			node_value_mem[IdxW'(new_q)] <= key_q;
			node_next_mem[IdxW'(new_q)]  <= cur_node ? cur_q : Nil;
		end else if (cmd.unlink && (prev_q < Nil)) begin
			node_next_mem[IdxW'(prev_q)] <= rd_next_ok ? rd_next_q : Nil;
		end else if (cmd.free_node) begin
			node_next_mem[IdxW'(cur_q)] <= free_q;
		end else if (cmd.set_status && (prev_q < Nil) && link_pending) begin
			node_next_mem[IdxW'(prev_q)] <= new_q;
		end
	end

	assign stat.action      = action_q;
	assign stat.hash_done   = (rem_q == '0);
	assign stat.mod_done    = BigBuckets ? 1'b1 : (sum_q < BucketsC);
	assign stat.cur_is_node = cur_node;
	assign stat.val_lt      = (rd_value_q < key_q);
	assign stat.val_eq      = (rd_value_q == key_q);
	assign stat.steps_done  = (steps_q >= Nil);
	assign stat.pool_avail  = free_node_ok || (fresh_q < Nil);
	assign stat.out_taken   = out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_bucket = chs_pkg::BucketOutWidth'(sum_q);

endmodule

[hw/rtl/chained_hash_set_unit.sv]
// Top level of the chained hash set unit.
// Each request runs the digit-sum hash, the bucket reduction and a walk of the bucket chain,
// then an update step for a new insert or a delete hit.
// Throughput: one transaction at a time.
// Reset: arst_n clears bucket heads to empty, the free list and fresh count; node
// memory has no reset and holds nothing until a node is linked.
module chained_hash_set_unit #(
	parameter int unsigned Buckets  = chs_pkg::BucketsDefault,
	parameter int unsigned PoolSize = chs_pkg::PoolSizeDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	chs_stream_if.sink    request,
	chs_stream_if.source  response
);

	chs_pkg::chs_cmd_t  cmd;
	chs_pkg::chs_stat_t stat;
	logic out_valid;

	// The controller sequences hash, chain walk and update; the datapath holds state.
	// A new request is taken only after the previous response has been taken.
	chs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Request payload: action in the top bits, key below. Response: status, bucket.
	chs_datapath #(.Buckets(Buckets), .PoolSize(PoolSize)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_action  (request.data[17:16]),
		.in_key     (request.data[15:0]),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (response.ready),
		.out_status (response.data[6:4]),
		.out_bucket (response.data[3:0])
	);

	assign response.valid = out_valid;

	// A response is never raised while a new request is being taken.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_valid_set |-> !request.ready)
		else $error("response raised while idle");

	// After a request is taken the unit is busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> !request.ready)
		else $error("request taken twice");

	// A status code beyond pool full never appears.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid |-> (response.data[6:4] <= 3'd5))
		else $error("bad status code");

endmodule
